// File: sv/assert_macros.svh
// Shared assertion macros for the scan block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and disabled in reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge and disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/cgs_pkg.sv
package cgs_pkg;

    // Matrix geometry.
    localparam int LAST_LINE   = 10;
    localparam int LINES       = LAST_LINE + 1;
    localparam int STORE_DEPTH = 2 * LINES;
    localparam int WORD_W      = 28;
    localparam int PIN_W       = 16;

    // Command codes passed from the front end to the back end.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ECHO = 2'd1;
    localparam logic [1:0] CMD_WORD = 2'd2;

    // One classified item.
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data;
        logic [WORD_W-1:0] word;
    } t_cmd;

endpackage

// File: sv/charlieplex_greyscale_scan_with_rx.sv
// Charlieplexed 11-line LED matrix scanner with 3-bit greyscale and a serial
// frame receiver. Each input beat is a scan tick (tuser 0) or a received byte
// (tuser 1); each gives exactly one output beat: a tick gives the 16 pin drive
// levels and enables of the current line, a byte is echoed back with tuser 1.
// Start bytes (bit 7 set) plus three 7-bit bytes form a 28-bit line word that
// fills the back bank; the banks swap after the last line. The block takes one
// beat per clock while the output is taken. An accepted beat is registered in
// the queue, and the back end loads its result from there into the output
// register once that register is free or being taken. The front end assembles
// words and classifies beats, a two-entry queue decouples it from the back
// end, which does one frame-store access per beat; a stalled output fills the
// queue and then holds off the input.
module charlieplex_greyscale_scan_with_rx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] line_level, [31:16] line_enable, [39:32] echo_byte
    output logic        o_m_tuser    // [0] echo_valid
);
    import cgs_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && !full;

    cgs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_s_tuser),
        .i_byte   (i_s_tdata),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    cgs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    cgs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser),
        .i_ready (i_m_tready)
    );

endmodule

// File: sv/cgs_front.sv
module cgs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_action,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output cgs_pkg::t_cmd o_cmd
);
    import cgs_pkg::*;

    logic              r_active;
    logic [1:0]        r_count;
    logic [WORD_W-1:0] r_acc;
    logic              n_active;
    logic [1:0]        n_count;
    logic [WORD_W-1:0] n_acc;
    logic [WORD_W-1:0] acc_shift;

    assign acc_shift = {r_acc[WORD_W-8:0], i_byte[6:0]};
    assign o_push    = i_accept;

    // Classify the beat and assemble 28-bit words from serial bytes.
    always_comb begin
        n_active    = r_active;
        n_count     = r_count;
        n_acc       = r_acc;
        o_cmd.kind  = CMD_TICK;
        o_cmd.data  = i_byte;
        o_cmd.word  = acc_shift;
        if (i_action) begin
            o_cmd.kind = CMD_ECHO;
            if (i_byte[7]) begin
                n_active = 1'b1;
                n_count  = 2'd1;
                n_acc    = {{(WORD_W-7){1'b0}}, i_byte[6:0]};
            end else if (r_active) begin
                n_acc   = acc_shift;
                n_count = r_count + 2'd1;
                if (r_count == 2'd3) begin
                    n_active   = 1'b0;
                    o_cmd.kind = CMD_WORD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= 2'd0;
            r_acc    <= '0;
        end else if (i_accept) begin
            r_active <= n_active;
            r_count  <= n_count;
            r_acc    <= n_acc;
        end
    end

endmodule

// File: sv/cgs_fifo.sv
module cgs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cgs_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output cgs_pkg::t_cmd o_cmd
);
    import cgs_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    // Two-entry queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: sv/cgs_back.sv
module cgs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  cgs_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    output logic [39:0]   o_data,
    output logic          o_user,
    input  logic          i_ready
);
    import cgs_pkg::*;

    logic [WORD_W-1:0] r_store [STORE_DEPTH];
    logic              r_bank;
    logic [3:0]        r_wline;
    logic [1:0]        r_plane;
    logic [2:0]        r_rep;
    logic [3:0]        r_line;
    logic              r_out_valid;
    logic [39:0]       r_out_data;
    logic              r_out_user;

    logic              n_bank;
    logic [3:0]        n_wline;
    logic [1:0]        n_plane;
    logic [2:0]        n_rep;
    logic [3:0]        n_line;
    logic [39:0]       n_out_data;
    logic              n_out_user;
    logic              wr_en;
    logic [4:0]        wr_idx;

    logic [1:0]        pl;
    logic [3:0]        line;
    logic              is_last;
    logic [4:0]        rd_idx;
    logic [WORD_W-1:0] word;
    logic [10:0]       bits;
    logic [10:0]       below;
    logic [10:0]       ins;
    logic [PIN_W-1:0]  pin;
    logic [PIN_W-1:0]  en;
    logic [PIN_W-1:0]  lv;
    logic [2:0]        rep_dec;
    logic [3:0]        wl;

    assign o_pop   = !i_empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;

    // Scan position and the line word read from the shown bank.
    always_comb begin
        pl      = (r_plane > 2'd2) ? 2'd0 : r_plane;
        line    = (r_line > 4'(LAST_LINE)) ? 4'd0 : r_line;
        is_last = (line == 4'(LAST_LINE));
        rd_idx  = r_bank ? (5'(line) + 5'(LINES)) : 5'(line);
        word    = r_store[rd_idx];
    end

    // Plane bits, gap at the line's own position, and pin mapping.
    always_comb begin
        case (pl)
            2'd0: begin
                bits = is_last ? {1'b0, word[9:0]} : {2'b0, word[8:0]};
            end
            2'd1: begin
                bits = is_last ? {1'b0, word[19:10]} : {2'b0, word[17:9]};
            end
            default: begin
                bits = is_last ? {3'b0, word[27:20]} : {2'b0, word[26:18]};
            end
        endcase
        below = (11'd1 << line) - 11'd1;
        ins   = (bits & below) | ((bits & ~below) << 1);
        pin   = (line < 4'd5) ? (16'd1 << line) : (16'd1 << (line + 4'd5));
        en    = {11'b0, ins[4:0]} | {ins[10:5], 10'b0} | pin;
        lv    = is_last ? (pin & en) : (~pin & en);
    end

    // Next state of scan, bank and the output beat.
    always_comb begin
        n_bank     = r_bank;
        n_wline    = r_wline;
        n_plane    = r_plane;
        n_rep      = r_rep;
        n_line     = r_line;
        n_out_data = 40'd0;
        n_out_user = 1'b0;
        wr_en      = 1'b0;
        wl         = (r_wline > 4'(LAST_LINE)) ? 4'd0 : r_wline;
        wr_idx     = r_bank ? 5'(wl) : (5'(wl) + 5'(LINES));
        rep_dec    = r_rep - 3'd1;
        case (i_cmd.kind)
            CMD_TICK: begin
                n_out_data = {8'd0, en, lv};
                n_plane    = pl;
                if (is_last) begin
                    n_line = 4'd0;
                    n_rep  = rep_dec;
                    if (rep_dec == 3'd0) begin
                        n_plane = (pl >= 2'd2) ? 2'd0 : (pl + 2'd1);
                        n_rep   = 3'd1 << n_plane;
                    end
                end else begin
                    n_line = line + 4'd1;
                end
            end
            CMD_WORD: begin
                n_out_data = {i_cmd.data, 32'd0};
                n_out_user = 1'b1;
                wr_en      = 1'b1;
                if (wl == 4'(LAST_LINE)) begin
                    n_wline = 4'd0;
                    n_bank  = ~r_bank;
                end else begin
                    n_wline = wl + 4'd1;
                end
            end
            default: begin
                n_out_data = {i_cmd.data, 32'd0};
                n_out_user = 1'b1;
            end
        endcase
    end

    // Frame store, both banks, reset to all ones.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_store[k] <= '1;
            end
        end else if (o_pop && wr_en) begin
            r_store[wr_idx] <= i_cmd.word;
        end
    end

    // Scan and bank control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_wline <= 4'd0;
            r_plane <= 2'd0;
            r_rep   <= 3'd1;
            r_line  <= 4'd0;
        end else if (o_pop) begin
            r_bank  <= n_bank;
            r_wline <= n_wline;
            r_plane <= n_plane;
            r_rep   <= n_rep;
            r_line  <= n_line;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

endmodule

// File: sv/cgs_checker.sv
`include "assert_macros.svh"

module cgs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic        out_echo;
    logic        out_scan;
    logic        out_stall;
    logic        scan_ok;
    logic        pin_ok;
    logic [40:0] out_word;

    // Views of the output beat used by the checks below.
    assign out_echo  = o_m_tvalid && o_m_tuser;
    assign out_scan  = o_m_tvalid && !o_m_tuser;
    assign out_stall = o_m_tvalid && !i_m_tready;
    assign scan_ok   = (o_m_tdata[39:32] == 8'd0) && (o_m_tdata[31:16] != 16'd0);
    assign pin_ok    = (o_m_tdata[25:21] == 5'd0)
                    && ((o_m_tdata[15:0] & ~o_m_tdata[31:16]) == 16'd0);
    assign out_word  = {o_m_tuser, o_m_tdata};

    // An echo beat carries no line drive.
    `ASSERT_SAME(a_echo_no_drive, i_clk, i_rst_n, out_echo, o_m_tdata[31:0] == 32'd0)

    // A scan beat has no echo byte and always enables at least one pin.
    `ASSERT_SAME(a_scan_enabled, i_clk, i_rst_n, out_scan, scan_ok)

    // Pins 5 to 9 are never used, and a driven level is always an enabled pin.
    `ASSERT_SAME(a_pin_map, i_clk, i_rst_n, o_m_tvalid, pin_ok)

    // A stalled output beat holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(out_word))

endmodule

bind charlieplex_greyscale_scan_with_rx cgs_checker u_cgs_checker (.*);

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import cgs_pkg::*;

    // Beat kinds on the input tuser bit.
    localparam bit ACT_TICK = 1'b0;
    localparam bit ACT_BYTE = 1'b1;

    // Receiver byte framing.
    localparam logic [7:0] START_FLAG   = 8'h80;
    localparam logic [7:0] PAYLOAD_MASK = 8'h7f;

    // Plane layout inside a line word and pin mapping.
    localparam int          SHORT_PLANE_W = 9;
    localparam int          LONG_PLANE_W  = 10;
    localparam logic [31:0] SHORT_PLANE_MASK = 32'h1ff;
    localparam logic [31:0] LONG_PLANE_MASK  = 32'h3ff;
    localparam logic [31:0] LOW_PIN_MASK     = 32'h1f;
    localparam logic [31:0] HIGH_PIN_MASK    = 32'hfc00;
    localparam int          PIN_SKIP         = 5;
    localparam logic [WORD_W-1:0] BLANK_WORD = 28'hfffffff;

    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 8;
    localparam int REPORT_MAX   = 10;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_RHYTHM,
        SINK_TRICKLE
    } t_sink_mode;

    // One output beat as the block should present it.
    typedef struct packed {
        logic [PIN_W-1:0] level;
        logic [PIN_W-1:0] enable;
        logic             echo_valid;
        logic [7:0]       echo_byte;
    } t_scan_beat;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        i_s_tuser  = 1'b0;    // [0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;            // [15:0] line_level, [31:16] line_enable, [39:32] echo_byte
    logic        o_m_tuser;            // [0] echo_valid

    // Shadow copy of the display state.
    logic [WORD_W-1:0] frame_mem [0:STORE_DEPTH-1];
    bit                shown_bank;
    logic [3:0]        wr_line;
    bit                word_busy;
    logic [1:0]        byte_cnt;
    logic [WORD_W-1:0] word_acc;
    logic [1:0]        plane_sel;
    logic [2:0]        reps_left;
    logic [3:0]        scan_pos;

    t_scan_beat  pending_beats[$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned cycle_count;
    int unsigned burst_left;
    bit          steady_sender;
    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned sink_left;
    int unsigned sink_phase;
    t_sink_mode  sink_mode;

    charlieplex_greyscale_scan_with_rx u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Compute the beat for one accepted item and move the shadow state on.
    function automatic t_scan_beat predict_beat(input bit action, input logic [7:0] rx);
        t_scan_beat  res;
        logic [31:0] word, bits, below, pin, en, lv;
        int unsigned line, wl;
        res = '0;
        if (action == ACT_TICK) begin
            line = scan_pos;
            word = frame_mem[shown_bank * LINES + line];
            if (line != LAST_LINE) begin
                bits = (word >> (SHORT_PLANE_W * plane_sel)) & SHORT_PLANE_MASK;
            end else begin
                bits = (word >> (LONG_PLANE_W * plane_sel)) & LONG_PLANE_MASK;
            end
            // A line never drives itself through its own plane bit, so a zero
            // is slotted in at its position.
            below = (32'd1 << line) - 32'd1;
            bits  = (bits & below) | ((bits & ~below) << 1);
            pin   = 32'd1 << line;
            if (line >= PIN_SKIP) begin
                pin = pin << PIN_SKIP;
            end
            en = (bits & LOW_PIN_MASK) | (HIGH_PIN_MASK & (bits << PIN_SKIP)) | pin;
            lv = (line != LAST_LINE) ? (~pin & en) : (pin & en);
            res.level  = lv[PIN_W-1:0];
            res.enable = en[PIN_W-1:0];
            // Step the line, then the repeat count, then the plane.
            if (scan_pos == LAST_LINE) begin
                scan_pos  = '0;
                reps_left = reps_left - 3'd1;
                if (reps_left == 3'd0) begin
                    plane_sel = (plane_sel >= 2'd2) ? 2'd0 : plane_sel + 2'd1;
                    reps_left = 3'd1 << plane_sel;
                end
            end else begin
                scan_pos = scan_pos + 4'd1;
            end
        end else begin
            res.echo_valid = 1'b1;
            res.echo_byte  = rx;
            if ((rx & START_FLAG) != 0) begin
                word_busy = 1'b1;
                byte_cnt  = 2'd1;
                word_acc  = WORD_W'(rx & PAYLOAD_MASK);
            end else if (word_busy) begin
                word_acc = {word_acc[WORD_W-8:0], rx[6:0]};
                if (byte_cnt == 2'd3) begin
                    wl = (wr_line > LAST_LINE) ? 0 : wr_line;
                    frame_mem[(shown_bank ^ 1'b1) * LINES + wl] = word_acc;
                    wl++;
                    if (wl > LAST_LINE) begin
                        wl = 0;
                        shown_bank ^= 1'b1;
                    end
                    wr_line   = 4'(wl);
                    word_busy = 1'b0;
                end
                byte_cnt = byte_cnt + 2'd1;
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_count, what, want, got);
        end
    endtask

    // Offer one beat, in bursts with random gaps, and wait for the handshake.
    task automatic send_beat(input bit action, input logic [7:0] rx);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && !steady_sender) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rx;
        i_s_tuser  <= action;
        do @(posedge i_clk); while (!o_s_tready);
        pending_beats.push_back(predict_beat(action, rx));
        items_sent++;
    endtask

    // Stop offering until every expected beat has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_beats.size() != 0);
    endtask

    function automatic logic [7:0] pick_payload();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return PAYLOAD_MASK;
        return 8'($urandom_range(0, 127));
    endfunction

    // A complete line word, with scan ticks sometimes slipped in between bytes.
    task automatic send_word();
        send_beat(ACT_BYTE, START_FLAG | pick_payload());
        repeat (3) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat(ACT_TICK, 8'($urandom_range(0, 255)));
            end
            send_beat(ACT_BYTE, pick_payload());
        end
    endtask

    // Continuation bytes arriving with no word open are only echoed.
    task automatic test_stray_bytes();
        send_beat(ACT_BYTE, 8'h00);
        send_beat(ACT_BYTE, 8'h7f);
    endtask

    // A start byte mid-word throws the partial word away.
    task automatic test_word_restart();
        send_beat(ACT_BYTE, 8'hff);
        send_beat(ACT_BYTE, 8'h2a);
        send_beat(ACT_BYTE, 8'h80);
        send_beat(ACT_BYTE, 8'h00);
        send_beat(ACT_BYTE, 8'h7f);
        send_beat(ACT_BYTE, 8'h55);
    endtask

    // One full line sweep plus the wrap, including the last line's own drive rule.
    task automatic test_scan_sweep();
        for (int n = 0; n <= LINES; n++) begin
            send_beat(ACT_TICK, (n % 2 == 0) ? 8'hff : 8'h00);
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        hold_request  = 80;
        steady_sender = 1'b1;
        repeat (40) begin
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        steady_sender = 1'b0;
    endtask

    // The sender pauses until the block has delivered everything.
    task automatic test_drain_pause();
        repeat (12) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        wait_drained();
        repeat (4) @(posedge i_clk);
        repeat (12) send_beat(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed words and tick runs, plus broken words and noise.
    task automatic test_random_traffic();
        int unsigned first, pick, next_drain, cont;
        first      = items_sent;
        next_drain = 500;
        while (items_sent - first < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_word();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 30)) send_beat(ACT_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 93) begin
                cont = $urandom_range(0, 2);
                send_beat(ACT_BYTE, START_FLAG | pick_payload());
                repeat (cont) send_beat(ACT_BYTE, pick_payload());
            end else begin
                send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
            end
            if (items_sent - first >= next_drain) begin
                wait_drained();
                next_drain += 500;
            end
        end
    endtask

    // Receiver ready: a hold-off when asked, otherwise a changing stall pattern.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                sink_left = $urandom_range(20, 200);
            end else begin
                sink_left--;
            end
            sink_phase++;
            case (sink_mode)
                SINK_OPEN:    i_m_tready <= 1'b1;
                SINK_COIN:    i_m_tready <= 1'($urandom_range(0, 1));
                SINK_RHYTHM:  i_m_tready <= (sink_phase % 4) != 3;
                SINK_TRICKLE: i_m_tready <= ($urandom_range(0, 7) == 0);
                default:      i_m_tready <= 1'b1;
            endcase
        end
    end

    // Compare each delivered beat with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_scan_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch("beat with nothing pending", 32'd0, o_m_tdata[31:0]);
            end else begin
                want = pending_beats.pop_front();
                if (o_m_tdata[15:0] !== want.level)
                    flag_mismatch("line_level", 32'(want.level), 32'(o_m_tdata[15:0]));
                if (o_m_tdata[31:16] !== want.enable)
                    flag_mismatch("line_enable", 32'(want.enable), 32'(o_m_tdata[31:16]));
                if (o_m_tuser !== want.echo_valid)
                    flag_mismatch("echo_valid", 32'(want.echo_valid), 32'(o_m_tuser));
                if (o_m_tdata[39:32] !== want.echo_byte)
                    flag_mismatch("echo_byte", 32'(want.echo_byte), 32'(o_m_tdata[39:32]));
            end
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        for (int n = 0; n < STORE_DEPTH; n++) begin
            frame_mem[n] = BLANK_WORD;
        end
        shown_bank = 1'b0;
        wr_line    = '0;
        word_busy  = 1'b0;
        byte_cnt   = '0;
        word_acc   = '0;
        plane_sel  = '0;
        reps_left  = 3'd1;
        scan_pos   = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_stray_bytes();
        test_word_restart();
        test_scan_sweep();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_beats.size() != 0) begin
            flag_mismatch("beats never delivered", 32'd0, 32'(pending_beats.size()));
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/cgs_pkg.sv
sv/cgs_front.sv
sv/cgs_fifo.sv
sv/cgs_back.sv
sv/charlieplex_greyscale_scan_with_rx.sv
sv/cgs_checker.sv
test/tb.sv
